// ===== rtl/ordered_list_insert_remove_macros.svh =====
// Assertion macros for the ordered list block.
// Used by the top level; no other dependencies.
`ifndef ORDERED_LIST_INSERT_REMOVE_MACROS_SVH
`define ORDERED_LIST_INSERT_REMOVE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, reset-qualified
`define OLIR_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("olir: same-cycle check failed");
// Next-cycle implication, reset-qualified
`define OLIR_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("olir: next-cycle check failed");
`else
`define OLIR_ASSERT_NOW(lbl, pre, post)
`define OLIR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/olir_pkg.sv =====
// Package for the ordered list block: sizes, types, codes and helpers.
// No dependencies.
`timescale 1ns / 1ps

package olir_pkg;

	// Storage sizes
	localparam int unsigned CAPACITY   = 64;
	localparam int unsigned ELEM_WIDTH = 32;

	// Fixed field widths of the request and result
	localparam int unsigned CMD_W     = 3;
	localparam int unsigned POS_W     = 6;
	localparam int unsigned VAL_W     = 32;
	localparam int unsigned LEN_OUT_W = 7;
	localparam int unsigned STAT_W    = 2;

	// Derived widths
	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
	localparam int unsigned CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;
	localparam int unsigned MIN_W = (ELEM_WIDTH < VAL_W) ? ELEM_WIDTH : VAL_W;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [LEN_W-1:0]      len_t;
	typedef logic [CMP_W-1:0]      cmp_t;
	typedef logic [ELEM_WIDTH-1:0] elem_t;
	typedef logic [VAL_W-1:0]      word_t;
	typedef logic [CMD_W-1:0]      cmd_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [LEN_OUT_W-1:0]  len_out_t;
	typedef logic [STAT_W-1:0]     stat_t;

	// Command codes
	localparam cmd_t CMD_INSERT    = 3'd0;
	localparam cmd_t CMD_APPEND    = 3'd1;
	localparam cmd_t CMD_REMOVE    = 3'd2;
	localparam cmd_t CMD_READ      = 3'd3;
	localparam cmd_t CMD_OVERWRITE = 3'd4;
	localparam cmd_t CMD_SWAP      = 3'd5;

	// Status codes
	localparam stat_t STAT_OK    = 2'd0;
	localparam stat_t STAT_RANGE = 2'd1;
	localparam stat_t STAT_FULL  = 2'd2;

	// Operation broadcast along the row of cells
	typedef enum logic [2:0] {
		OP_NONE,
		OP_INSERT,
		OP_REMOVE,
		OP_WRITE,
		OP_SWAP
	} op_t;

	typedef struct packed {
		op_t   op;
		cmp_t  pos;
		cmp_t  pos2;
		elem_t val;
		elem_t swap_a;
		elem_t swap_b;
	} cell_cmd_t;

	// Request word to element width (zero fill or truncate)
	function automatic elem_t to_elem(input word_t v);
		elem_t r;
		r = '0;
		for (int i = 0; i < MIN_W; i++) begin
			r[i] = v[i];
		end
		return r;
	endfunction

	// Element to result word width (zero fill or truncate)
	function automatic word_t from_elem(input elem_t e);
		word_t r;
		r = '0;
		for (int i = 0; i < MIN_W; i++) begin
			r[i] = e[i];
		end
		return r;
	endfunction

endpackage

// ===== rtl/olir_ifs.sv =====
// Request and result channel interfaces of the ordered list block.
// Depends on olir_pkg.
`timescale 1ns / 1ps

interface olir_req_if;
	logic              valid;
	logic              ready;
	olir_pkg::cmd_t    command;
	olir_pkg::pos_t    position;
	olir_pkg::pos_t    other_position;
	olir_pkg::word_t   element_value;

	modport source (output valid, output command, output position,
		output other_position, output element_value, input ready);
	modport sink (input valid, input command, input position,
		input other_position, input element_value, output ready);
endinterface

interface olir_rsp_if;
	logic                valid;
	logic                ready;
	olir_pkg::word_t     read_value;
	olir_pkg::len_out_t  list_length;
	olir_pkg::stat_t     status;

	modport source (output valid, output read_value, output list_length,
		output status, input ready);
	modport sink (input valid, input read_value, input list_length,
		input status, output ready);
endinterface

// ===== rtl/ordered_list_insert_remove.sv =====
// Ordered list with positional insert and remove, built as a row of cells.
// A request is captured when accepted and applied in the apply state, in which every cell
// shifts or loads at once and the result is registered; the apply waits while an unread
// result stalls. A new request is taken only once the last one has been applied.
// Reset clears the length and handshake state; entries hold no reset value.
`timescale 1ns / 1ps
`include "ordered_list_insert_remove_macros.svh"

module ordered_list_insert_remove (
	input  logic        clk,
	input  logic        arst_n,
	olir_req_if.sink    request,
	olir_rsp_if.source  result
);

	olir_pkg::cell_cmd_t cell_cmd;
	olir_pkg::cmp_t      rsel_a;
	olir_pkg::cmp_t      rsel_b;
	olir_pkg::elem_t     bus_a;
	olir_pkg::elem_t     bus_b;

	olir_pkg::elem_t     cell_data [olir_pkg::CAPACITY];
	olir_pkg::elem_t     cell_rd_a [olir_pkg::CAPACITY];
	olir_pkg::elem_t     cell_rd_b [olir_pkg::CAPACITY];
	logic [olir_pkg::CAPACITY-1:0] hit_a;

	olir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.result   (result),
		.rd_a     (bus_a),
		.rd_b     (bus_b),
		.rsel_a   (rsel_a),
		.rsel_b   (rsel_b),
		.cell_cmd (cell_cmd)
	);

	// Row of cells, each linked to its neighbours
	for (genvar g = 0; g < olir_pkg::CAPACITY; g++) begin : g_cell
		olir_pkg::elem_t prev_d;
		olir_pkg::elem_t next_d;

		if (g == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_mid_lo
			assign prev_d = cell_data[g-1];
		end
		if (g == olir_pkg::CAPACITY - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_mid_hi
			assign next_d = cell_data[g+1];
		end

		olir_cell u_cell (
			.clk       (clk),
			.idx       (olir_pkg::idx_t'(g)),
			.cmd       (cell_cmd),
			.prev_data (prev_d),
			.next_data (next_d),
			.rsel_a    (rsel_a),
			.rsel_b    (rsel_b),
			.data      (cell_data[g]),
			.rd_a      (cell_rd_a[g]),
			.rd_b      (cell_rd_b[g]),
			.hit_a     (hit_a[g])
		);
	end

	// OR-combine the read taps; at most one cell drives each bus
	always_comb begin
		bus_a = '0;
		bus_b = '0;
		for (int i = 0; i < olir_pkg::CAPACITY; i++) begin
			bus_a = bus_a | cell_rd_a[i];
			bus_b = bus_b | cell_rd_b[i];
		end
	end

	// Checks
	`OLIR_ASSERT_NEXT(a_one_in_flight, request.valid && request.ready, !request.ready)
	`OLIR_ASSERT_NOW(a_single_hit, 1'b1, $onehot0(hit_a))
	`OLIR_ASSERT_NOW(a_full_len, result.valid && (result.status == olir_pkg::STAT_FULL),
		result.list_length == olir_pkg::len_out_t'(olir_pkg::CAPACITY))
	`OLIR_ASSERT_NOW(a_err_zero, result.valid && (result.status != olir_pkg::STAT_OK),
		result.read_value == '0)

endmodule

// ===== rtl/olir_cell.sv =====
// One storage cell of the list: holds one entry, shifts to/from neighbours.
// Depends on olir_pkg.
`timescale 1ns / 1ps

module olir_cell (
	input  logic                 clk,
	input  olir_pkg::idx_t       idx,
	input  olir_pkg::cell_cmd_t  cmd,
	input  olir_pkg::elem_t      prev_data,
	input  olir_pkg::elem_t      next_data,
	input  olir_pkg::cmp_t       rsel_a,
	input  olir_pkg::cmp_t       rsel_b,
	output olir_pkg::elem_t      data,
	output olir_pkg::elem_t      rd_a,
	output olir_pkg::elem_t      rd_b,
	output logic                 hit_a
);

	olir_pkg::elem_t data_q;
	olir_pkg::cmp_t  my_idx;
	logic            at_pos;
	logic            at_pos2;
	logic            above_pos;

	assign my_idx    = olir_pkg::cmp_t'(idx);
	assign at_pos    = (my_idx == cmd.pos);
	assign at_pos2   = (my_idx == cmd.pos2);
	assign above_pos = (my_idx > cmd.pos);

	// Entry update: shift up on insert, shift down on remove, load on write, exchange on swap
	always_ff @(posedge clk) begin
		case (cmd.op)
			olir_pkg::OP_INSERT: begin
				if (at_pos) begin
					data_q <= cmd.val;
				end else if (above_pos) begin
					data_q <= prev_data;
				end
			end
			olir_pkg::OP_REMOVE: begin
				if (at_pos || above_pos) begin
					data_q <= next_data;
				end
			end
			olir_pkg::OP_WRITE: begin
				if (at_pos) begin
					data_q <= cmd.val;
				end
			end
			olir_pkg::OP_SWAP: begin
				if (at_pos) begin
					data_q <= cmd.swap_b;
				end else if (at_pos2) begin
					data_q <= cmd.swap_a;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	// Read taps onto the two OR buses
	assign hit_a = (my_idx == rsel_a);
	assign rd_a  = hit_a ? data_q : '0;
	assign rd_b  = (my_idx == rsel_b) ? data_q : '0;
	assign data  = data_q;

endmodule

// ===== rtl/olir_ctrl.sv =====
// Sequencer of the ordered list: range checks, length, result register.
// Depends on olir_pkg and the channel interfaces.
`timescale 1ns / 1ps

module olir_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	olir_req_if.sink             request,
	olir_rsp_if.source           result,
	input  olir_pkg::elem_t      rd_a,
	input  olir_pkg::elem_t      rd_b,
	output olir_pkg::cmp_t       rsel_a,
	output olir_pkg::cmp_t       rsel_b,
	output olir_pkg::cell_cmd_t  cell_cmd
);

	localparam logic S_IDLE  = 1'b0;
	localparam logic S_APPLY = 1'b1;

	logic             state_q;
	logic             accept;
	logic             fire;
	olir_pkg::len_t   len_q;

	// Captured request
	olir_pkg::op_t    op_q;
	olir_pkg::cmp_t   tgt_q;
	olir_pkg::cmp_t   pos2_q;
	olir_pkg::elem_t  val_q;
	olir_pkg::elem_t  rda_q;
	olir_pkg::elem_t  rdb_q;
	olir_pkg::stat_t  stat_q;
	olir_pkg::word_t  rdv_q;
	olir_pkg::len_t   len_nx_q;

	// Result register
	logic               out_valid_q;
	olir_pkg::word_t    out_rd_q;
	olir_pkg::len_out_t out_len_q;
	olir_pkg::stat_t    out_stat_q;

	// Decode
	olir_pkg::cmp_t   pos_c;
	olir_pkg::cmp_t   pos2_c;
	olir_pkg::cmp_t   len_c;
	olir_pkg::cmp_t   cap_c;
	olir_pkg::cmp_t   tgt_d;
	olir_pkg::op_t    op_d;
	olir_pkg::stat_t  stat_d;
	olir_pkg::word_t  rdv_d;
	olir_pkg::len_t   len_d;

	assign accept = request.valid && request.ready;
	assign fire   = (state_q == S_APPLY) && (!out_valid_q || result.ready);

	assign request.ready = (state_q == S_IDLE);

	assign pos_c  = olir_pkg::cmp_t'(request.position);
	assign pos2_c = olir_pkg::cmp_t'(request.other_position);
	assign len_c  = olir_pkg::cmp_t'(len_q);
	assign cap_c  = olir_pkg::cmp_t'(olir_pkg::CAPACITY);

	// Read selects go straight to the cells during the accept cycle
	assign rsel_a = pos_c;
	assign rsel_b = pos2_c;

	// Range and capacity checks on the incoming request
	always_comb begin
		op_d   = olir_pkg::OP_NONE;
		stat_d = olir_pkg::STAT_OK;
		tgt_d  = pos_c;
		rdv_d  = '0;
		len_d  = len_q;
		case (request.command)
			olir_pkg::CMD_INSERT, olir_pkg::CMD_APPEND: begin
				if (request.command == olir_pkg::CMD_APPEND) begin
					tgt_d = len_c;
				end
				if (tgt_d > len_c) begin
					stat_d = olir_pkg::STAT_RANGE;
				end else if (len_c >= cap_c) begin
					stat_d = olir_pkg::STAT_FULL;
				end else begin
					op_d  = olir_pkg::OP_INSERT;
					len_d = olir_pkg::len_t'(len_q + 1'b1);
				end
			end
			olir_pkg::CMD_REMOVE: begin
				if (pos_c >= len_c) begin
					stat_d = olir_pkg::STAT_RANGE;
				end else begin
					op_d  = olir_pkg::OP_REMOVE;
					rdv_d = olir_pkg::from_elem(rd_a);
					len_d = olir_pkg::len_t'(len_q - 1'b1);
				end
			end
			olir_pkg::CMD_READ: begin
				if (pos_c >= len_c) begin
					stat_d = olir_pkg::STAT_RANGE;
				end else begin
					rdv_d = olir_pkg::from_elem(rd_a);
				end
			end
			olir_pkg::CMD_OVERWRITE: begin
				if (pos_c >= len_c) begin
					stat_d = olir_pkg::STAT_RANGE;
				end else begin
					op_d = olir_pkg::OP_WRITE;
				end
			end
			olir_pkg::CMD_SWAP: begin
				if ((pos_c >= len_c) || (pos2_c >= len_c)) begin
					stat_d = olir_pkg::STAT_RANGE;
				end else begin
					op_d = olir_pkg::OP_SWAP;
				end
			end
			default: begin
				op_d = olir_pkg::OP_NONE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			op_q        <= olir_pkg::OP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= S_APPLY;
				op_q    <= op_d;
			end else if (fire) begin
				state_q <= S_IDLE;
				len_q   <= len_nx_q;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q    <= tgt_d;
			pos2_q   <= pos2_c;
			val_q    <= olir_pkg::to_elem(request.element_value);
			rda_q    <= rd_a;
			rdb_q    <= rd_b;
			stat_q   <= stat_d;
			rdv_q    <= rdv_d;
			len_nx_q <= len_d;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			out_rd_q   <= rdv_q;
			out_len_q  <= olir_pkg::len_out_t'(len_nx_q);
			out_stat_q <= stat_q;
		end
	end

	// Broadcast to the cells only in the cycle the result is committed
	always_comb begin
		cell_cmd.op     = fire ? op_q : olir_pkg::OP_NONE;
		cell_cmd.pos    = tgt_q;
		cell_cmd.pos2   = pos2_q;
		cell_cmd.val    = val_q;
		cell_cmd.swap_a = rda_q;
		cell_cmd.swap_b = rdb_q;
	end

	assign result.valid       = out_valid_q;
	assign result.read_value  = out_rd_q;
	assign result.list_length = out_len_q;
	assign result.status      = out_stat_q;

endmodule
